@@ rtl/e2q_pkg.sv @@
`timescale 1ns / 1ps
package e2q_pkg;

  localparam int AngW = 19;
  localparam int OutW = 18;
  localparam int CordW = 34;
  localparam int ZW = 34;
  localparam int TrigW = 22;
  localparam int ProdW = 66;
  localparam int TableLen = 24;
  localparam int DefStages = 16;

  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [OutW-1:0] OneQ16 = 18'sd65536;

  typedef struct packed {
    logic signed [TrigW-1:0] s;
    logic signed [TrigW-1:0] c;
  } sincos_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0: r = 34'sd843314856;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;
      5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd67021686;
      5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/e2q_cordic.sv @@
`timescale 1ns / 1ps
module e2q_cordic #(
  parameter int STAGES = 16
) (
  input  logic clk,
  input  logic signed [e2q_pkg::AngW-1:0] angle,
  output e2q_pkg::sincos_t sc
);
  import e2q_pkg::*;

  localparam int N = (STAGES < TableLen) ? STAGES : TableLen;

  logic signed [CordW-1:0] xs [0:N];
  logic signed [CordW-1:0] ys [0:N];
  logic signed [ZW-1:0] zs [0:N];
  logic neg [0:N];
  logic signed [ZW-1:0] z0;
  logic signed [CordW-1:0] xf;
  logic signed [CordW-1:0] yf;
  logic signed [CordW-1:0] xr;
  logic signed [CordW-1:0] yr;

  assign z0 = ZW'(angle) <<< 14;

  // fold by a half turn so the rotator sees [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    xs[0] <= GainQ30;
    ys[0] <= '0;
    if (z0 > HalfPiQ30) begin
      zs[0] <= z0 - PiQ30;
      neg[0] <= 1'b1;
    end else if (z0 < -HalfPiQ30) begin
      zs[0] <= z0 + PiQ30;
      neg[0] <= 1'b1;
    end else begin
      zs[0] <= z0;
      neg[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      neg[i+1] <= neg[i];
      if (!zs[i][ZW-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q30(5'(i));
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q30(5'(i));
      end
    end
  end

  assign xf = neg[N] ? -xs[N] : xs[N];
  assign yf = neg[N] ? -ys[N] : ys[N];
  assign xr = (xf + CordW'(512)) >>> 10;
  assign yr = (yf + CordW'(512)) >>> 10;

  always_ff @(posedge clk) begin
    sc.c <= xr[TrigW-1:0];
    sc.s <= yr[TrigW-1:0];
  end

endmodule

@@ rtl/e2q_combine.sv @@
`timescale 1ns / 1ps
module e2q_combine (
  input  logic clk,
  input  e2q_pkg::sincos_t hd,
  input  e2q_pkg::sincos_t pt,
  input  e2q_pkg::sincos_t bk,
  input  logic conj,
  output logic signed [e2q_pkg::OutW-1:0] quat_w,
  output logic signed [e2q_pkg::OutW-1:0] quat_x,
  output logic signed [e2q_pkg::OutW-1:0] quat_y,
  output logic signed [e2q_pkg::OutW-1:0] quat_z
);
  import e2q_pkg::*;

  localparam int PairW = 2 * TrigW;

  // stage 1: pair products of heading and pitch, bank held alongside
  logic signed [PairW-1:0] chcp, shsp, chsp, shcp;
  sincos_t bk1;
  logic conj1, conj2, conj3;
  // stage 2: triple products, split into high and low partial products
  logic signed [PairW-1:0] ph [0:7];
  logic signed [PairW:0] pl [0:7];
  // stage 3: sums
  logic signed [ProdW-1:0] sw, sx, sy, sz;

  // upper half of the pair, signed, times a bank term
  function automatic logic signed [PairW-1:0] mul_hi(input logic signed [PairW-1:0] a,
                                                     input logic signed [TrigW-1:0] b);
    logic signed [TrigW-1:0] h;
    h = a[PairW-1:TrigW];
    return h * b;
  endfunction

  // lower half of the pair, unsigned, times a bank term
  function automatic logic signed [PairW:0] mul_lo(input logic signed [PairW-1:0] a,
                                                   input logic signed [TrigW-1:0] b);
    logic signed [TrigW:0] l;
    l = {1'b0, a[TrigW-1:0]};
    return l * b;
  endfunction

  function automatic logic signed [OutW-1:0] fin(input logic signed [ProdW-1:0] v,
                                                 input logic ng);
    logic signed [ProdW-1:0] r;
    logic signed [OutW-1:0] q;
    r = (v + (ProdW'(1) <<< 43)) >>> 44;
    if (r > ProdW'(OneQ16)) q = OneQ16;
    else if (r < -ProdW'(OneQ16)) q = -OneQ16;
    else q = r[OutW-1:0];
    return ng ? -q : q;
  endfunction

  always_ff @(posedge clk) begin
    chcp <= hd.c * pt.c;
    shsp <= hd.s * pt.s;
    chsp <= hd.c * pt.s;
    shcp <= hd.s * pt.c;
    bk1 <= bk;
    conj1 <= conj;
    ph[0] <= mul_hi(chcp, bk1.c);
    pl[0] <= mul_lo(chcp, bk1.c);
    ph[1] <= mul_hi(shsp, bk1.s);
    pl[1] <= mul_lo(shsp, bk1.s);
    ph[2] <= mul_hi(chsp, bk1.c);
    pl[2] <= mul_lo(chsp, bk1.c);
    ph[3] <= mul_hi(shcp, bk1.s);
    pl[3] <= mul_lo(shcp, bk1.s);
    ph[4] <= mul_hi(shcp, bk1.c);
    pl[4] <= mul_lo(shcp, bk1.c);
    ph[5] <= mul_hi(chsp, bk1.s);
    pl[5] <= mul_lo(chsp, bk1.s);
    ph[6] <= mul_hi(chcp, bk1.s);
    pl[6] <= mul_lo(chcp, bk1.s);
    ph[7] <= mul_hi(shsp, bk1.c);
    pl[7] <= mul_lo(shsp, bk1.c);
    conj2 <= conj1;
    sw <= ((ProdW'(ph[0]) + ProdW'(ph[1])) <<< TrigW) + ProdW'(pl[0]) + ProdW'(pl[1]);
    sx <= ((ProdW'(ph[2]) + ProdW'(ph[3])) <<< TrigW) + ProdW'(pl[2]) + ProdW'(pl[3]);
    sy <= ((ProdW'(ph[4]) - ProdW'(ph[5])) <<< TrigW) + ProdW'(pl[4]) - ProdW'(pl[5]);
    sz <= ((ProdW'(ph[6]) - ProdW'(ph[7])) <<< TrigW) + ProdW'(pl[6]) - ProdW'(pl[7]);
    conj3 <= conj2;
    quat_w <= fin(sw, 1'b0);
    quat_x <= fin(sx, conj3);
    quat_y <= fin(sy, conj3);
    quat_z <= fin(sz, conj3);
  end

endmodule

@@ rtl/euler_to_quaternion.sv @@
`timescale 1ns / 1ps
// euler angles to rotation quaternion, fully pipelined
// input: pulse start with func and three Q3.15 angles; busy is always low,
// so a new word may be given every cycle
// output: done is high for one cycle with quat_w..quat_z in Q1.16,
// saturated to +-1.0; func set gives the conjugate
// path from start to done: fold stage, one cordic stage per rotation step,
// rounding register, then four stages of products, sums and saturation
// throughput: one word per cycle, set by the unrolled cordic rotators
// reset clears only the valid pipeline; data registers are left as is
// the receiver cannot stall, done is not held off
module euler_to_quaternion #(
  parameter int CORDIC_STAGES = e2q_pkg::DefStages
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic func,
  input  logic signed [e2q_pkg::AngW-1:0] heading_angle,
  input  logic signed [e2q_pkg::AngW-1:0] pitch_angle,
  input  logic signed [e2q_pkg::AngW-1:0] bank_angle,
  output logic done,
  output logic signed [e2q_pkg::OutW-1:0] quat_w,
  output logic signed [e2q_pkg::OutW-1:0] quat_x,
  output logic signed [e2q_pkg::OutW-1:0] quat_y,
  output logic signed [e2q_pkg::OutW-1:0] quat_z
);
  import e2q_pkg::*;

  localparam int N = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
  localparam int Lat = N + 6;

  logic [Lat-1:0] vld;
  logic [N+1:0] fpipe;
  sincos_t hd, pt, bk;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Lat-2:0], start};
  end

  always_ff @(posedge clk) begin
    fpipe <= {fpipe[N:0], func};
  end

  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_hd (.clk, .angle(heading_angle), .sc(hd));
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_pt (.clk, .angle(pitch_angle), .sc(pt));
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_bk (.clk, .angle(bank_angle), .sc(bk));

  e2q_combine u_comb (
    .clk, .hd, .pt, .bk, .conj(fpipe[N+1]),
    .quat_w, .quat_x, .quat_y, .quat_z
  );

  assign done = vld[Lat-1];

`ifndef NO_ASSERTIONS
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    vld[Lat-2] |=> done) else $error("lost word");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat_w <= OneQ16 && quat_w >= -OneQ16)) else $error("w range");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import e2q_pkg::*;

  localparam int Stages = DefStages;
  localparam int Latency = Stages + 6;
  localparam int LimitCycles = 200000;
  localparam logic ObjToInertial = 1'b0;
  localparam logic InertialToObject = 1'b1;
  localparam int AngMax = 262143;
  localparam int AngMin = -262144;

  typedef struct packed {
    logic signed [OutW-1:0] w;
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic func = 1'b0;
  logic signed [AngW-1:0] heading_angle = '0;
  logic signed [AngW-1:0] pitch_angle = '0;
  logic signed [AngW-1:0] bank_angle = '0;
  logic busy, done;
  logic signed [OutW-1:0] quat_w, quat_x, quat_y, quat_z;

  quat_t expected_quats[$];
  int mismatches = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  euler_to_quaternion #(.CORDIC_STAGES(Stages)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .heading_angle(heading_angle), .pitch_angle(pitch_angle),
    .bank_angle(bank_angle), .done(done), .quat_w(quat_w), .quat_x(quat_x),
    .quat_y(quat_y), .quat_z(quat_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // sine and cosine of half the angle, Q20
  function automatic void half_angle_trig(input logic signed [AngW-1:0] ang,
                                          output longint s, output longint c);
    longint z, x, y, dx, dy, half_pi, pi_q30;
    bit folded;
    half_pi = HalfPiQ30;
    pi_q30 = PiQ30;
    z = longint'(ang) * 16384;
    folded = 1'b0;
    x = GainQ30;
    y = 0;
    if (z > half_pi) begin
      z -= pi_q30;
      folded = 1'b1;
    end else if (z < -half_pi) begin
      z += pi_q30;
      folded = 1'b1;
    end
    for (int i = 0; i < Stages && i < TableLen; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_q30(5'(i)));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_q30(5'(i)));
      end
    end
    if (folded) begin
      x = -x;
      y = -y;
    end
    c = floor_shr(x + 512, 10);
    s = floor_shr(y + 512, 10);
  endfunction

  function automatic logic signed [OutW-1:0] round_sat(longint p, longint q);
    logic signed [127:0] sum;
    longint v;
    sum = 128'(signed'(p)) + 128'(signed'(q)) + (128'sd1 <<< 43);
    v = longint'(sum >>> 44);
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return OutW'(v);
  endfunction

  function automatic longint mul3(longint a, longint b, longint c);
    return a * b * c;
  endfunction

  function automatic quat_t euler_quat(logic f, logic signed [AngW-1:0] h,
                                       logic signed [AngW-1:0] p,
                                       logic signed [AngW-1:0] b);
    longint sh, ch, sp, cp, sb, cb;
    quat_t q;
    half_angle_trig(h, sh, ch);
    half_angle_trig(p, sp, cp);
    half_angle_trig(b, sb, cb);
    // triple products of Q20 values fit in 63 bits
    q.w = round_sat(mul3(ch, cp, cb), mul3(sh, sp, sb));
    q.x = round_sat(mul3(ch, sp, cb), mul3(sh, cp, sb));
    q.y = round_sat(mul3(sh, cp, cb), -mul3(ch, sp, sb));
    q.z = round_sat(mul3(ch, cp, sb), -mul3(sh, sp, cb));
    if (f == InertialToObject) begin
      q.x = -q.x;
      q.y = -q.y;
      q.z = -q.z;
    end
    return q;
  endfunction

  task automatic send_word(input logic f, input int h, input int p, input int b);
    if (gaps_on) begin
      while ($urandom_range(99) < 16) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    func <= f;
    heading_angle <= AngW'(h);
    pitch_angle <= AngW'(p);
    bank_angle <= AngW'(b);
    do @(posedge clk); while (busy);
    expected_quats.push_back(euler_quat(f, AngW'(h), AngW'(p), AngW'(b)));
  endtask

  task automatic idle_line();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_angle();
    case ($urandom_range(3))
      0: return $urandom_range(411774) - 205887;
      1: return $urandom_range(524287) - 262144;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom_range(1) ? 205887 - $urandom_range(60000)
                                        : -205887 + $urandom_range(60000);
    endcase
  endfunction

  task automatic test_directed();
    int corners[10] = '{0, 1, -1, 51472, -51472, 102944, -102944,
                        205887, -205887, AngMax};
    for (int i = 0; i < 10; i++)
      send_word(i[0] ? InertialToObject : ObjToInertial, corners[i],
                corners[(i + 3) % 10], corners[(i + 7) % 10]);
    send_word(ObjToInertial, AngMin, AngMin, AngMin);
    send_word(InertialToObject, AngMax, AngMax, AngMax);
    send_word(ObjToInertial, AngMax, AngMin, 0);
    // half angle just past the fold points
    send_word(InertialToObject, 102944, -102945, 102945);
    send_word(ObjToInertial, 0, 0, 0);
    send_word(InertialToObject, 0, 0, 0);
    idle_line();
  endtask

  task automatic test_random();
    for (int n = 0; n < 1835; n++) begin
      gaps_on = !(n >= 600 && n < 900);
      send_word($urandom_range(1), rand_angle(), rand_angle(), rand_angle());
    end
    gaps_on = 1'b1;
    idle_line();
  endtask

  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && done) begin
      got = '{quat_w, quat_x, quat_y, quat_z};
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = expected_quats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("quat mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/e2q_pkg.sv
rtl/e2q_cordic.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
tb/tb.sv
